// ===== rtl/sha512_pkg.sv =====
// SHA-512 package: round constants, initial hash, datapath command/status types.
// Used by sha512_ctrl, sha512_dp and sha512_hash_engine.
`timescale 1ns / 1ps
package sha512_pkg;

   localparam int WordWidth  = 64;
   localparam int NumRounds  = 80;
   localparam int BlockWords = 16;

   typedef enum logic [2:0] {
      PUSH_NONE = 3'd0,
      PUSH_DATA = 3'd1,   // message word, or masked final word with pad
      PUSH_PAD  = 3'd2,   // 0x80 followed by zeros
      PUSH_ZERO = 3'd3,
      PUSH_LENH = 3'd4,
      PUSH_LENL = 3'd5
   } push_sel_type;

   typedef struct packed {
      push_sel_type push;
      logic         start;      // load working vars from chain value
      logic         round;      // run one round
      logic         finish;     // add working vars into chain value
      logic         reinit;     // load initial hash, clear length
      logic         add_len;    // add input bytes to length
      logic         shift_out;  // rotate chain value for output
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] fill;
      logic       last_round;
   } dp_status_type;

   function automatic logic [63:0] round_k(input logic [6:0] t);
      logic [63:0] k [0:79];
      k = '{
         64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
         64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
         64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
         64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
         64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
         64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
         64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
         64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
         64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
         64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
         64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
         64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
         64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
         64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
         64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
         64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
         64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
         64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
         64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
         64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      return k[t];
   endfunction

   function automatic logic [63:0] init_h(input logic [2:0] i);
      logic [63:0] h [0:7];
      h = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
            64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
            64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      return h[i];
   endfunction

endpackage

// ===== rtl/sha512_dp.sv =====
// SHA-512 datapath: schedule window, round unit, chain value, length, fill count.
// Depends on sha512_pkg.
`timescale 1ns / 1ps
module sha512_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  sha512_pkg::dp_cmd_type    cmd,
   input  logic [63:0]               in_word,
   input  logic [3:0]                in_bytes,
   output sha512_pkg::dp_status_type status,
   output logic [63:0]               out_word
);

   logic [63:0] w_ff [0:15];
   logic [63:0] h_ff [0:7];
   logic [63:0] v_ff [0:7];
   logic [63:0] len_ff, len_in;
   logic [3:0]  fill_ff;
   logic [6:0]  t_ff;
   logic [63:0] push_word;
   logic [63:0] keep;
   logic [6:0]  pad_sh;
   logic [63:0] w_new, t1, t2, s0, s1, w2, w15;
   logic        push_en;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int s);
      return (x >> s) | (x << (64 - s));
   endfunction

   // masked final word with pad byte after the last valid byte
   always_comb begin
      pad_sh = 7'(8 * (8 - in_bytes));
      keep   = (in_bytes == 4'd0) ? 64'd0 : (~64'd0 << pad_sh);
      unique case (cmd.push)
         sha512_pkg::PUSH_DATA:
            push_word = (in_bytes >= 4'd8) ? in_word
                      : ((in_word & keep) | (64'h80 << (pad_sh - 7'd8)));
         sha512_pkg::PUSH_PAD:  push_word = 64'h8000_0000_0000_0000;
         sha512_pkg::PUSH_LENH: push_word = {61'd0, len_ff[63:61]};
         sha512_pkg::PUSH_LENL: push_word = {len_ff[60:0], 3'd0};
         default:               push_word = 64'd0;
      endcase
      push_en = (cmd.push != sha512_pkg::PUSH_NONE);
   end

   // schedule as a 16-word shift window; w_ff[0] is word t
   always_comb begin
      w2  = w_ff[14];
      w15 = w_ff[1];
      s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
      s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (rotr(v_ff[4], 14) ^ rotr(v_ff[4], 18) ^ rotr(v_ff[4], 41))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + sha512_pkg::round_k(t_ff) + w_ff[0];
      t2 = (rotr(v_ff[0], 28) ^ rotr(v_ff[0], 34) ^ rotr(v_ff[0], 39))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      len_in = len_ff + (cmd.add_len ? ((in_bytes > 4'd8) ? 64'd8 : {60'd0, in_bytes}) : 64'd0);
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= push_word;
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_new;
      end
      if (cmd.start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha512_pkg::init_h(3'(i));
         len_ff  <= 64'd0;
         fill_ff <= 4'd0;
         t_ff    <= 7'd0;
      end else begin
         len_ff <= len_in;
         if (push_en) fill_ff <= fill_ff + 4'd1;
         if (cmd.start) t_ff <= 7'd0;
         else if (cmd.round) t_ff <= t_ff + 7'd1;
         if (cmd.finish) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end else if (cmd.shift_out) begin
            for (int i = 0; i < 7; i++) h_ff[i] <= h_ff[i + 1];
            h_ff[7] <= h_ff[0];
         end
      end
   end

   assign status.fill       = fill_ff;
   assign status.last_round = (t_ff == 7'(sha512_pkg::NumRounds - 1));
   assign out_word          = h_ff[0];

endmodule

// ===== rtl/sha512_ctrl.sv =====
// SHA-512 controller: sequences word pushes, padding, rounds and digest output.
// Depends on sha512_pkg.
`timescale 1ns / 1ps
module sha512_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [3:0]                req_byte_count,
   input  logic                      req_final_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_word_index,
   output logic                      rsp_digest_end,
   output sha512_pkg::dp_cmd_type    cmd,
   input  sha512_pkg::dp_status_type status
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_PAD   = 8'b00000010,  // pushing 0x80 word after a full final word
      S_ZERO  = 8'b00000100,  // zero fill, then upper length word
      S_LENL  = 8'b00001000,  // lower length word
      S_START = 8'b00010000,
      S_ROUND = 8'b00100000,
      S_FIN   = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type   state_ff, state_in;
   logic        final_ff, final_in;   // padding under way
   logic        pad_ff, pad_in;       // 0x80 word still owed
   logic [2:0]  idx_ff, idx_in;
   logic        len_in_ff, len_in_in; // length words are in the block
   logic        acc;

   assign acc       = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_word_index = idx_ff;
   assign rsp_digest_end = (idx_ff == 3'd7);

   always_comb begin
      state_in  = state_ff;
      final_in  = final_ff;
      pad_in    = pad_ff;
      idx_in    = idx_ff;
      len_in_in = len_in_ff;
      cmd       = '0;
      cmd.push  = sha512_pkg::PUSH_NONE;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            cmd.push    = sha512_pkg::PUSH_DATA;
            cmd.add_len = 1'b1;
            if (!req_final_word) begin
               state_in = (status.fill == 4'd15) ? S_START : S_IDLE;
            end else begin
               final_in = 1'b1;
               pad_in   = (req_byte_count >= 4'd8);
               state_in = (status.fill == 4'd15) ? S_START : (pad_in ? S_PAD : S_ZERO);
            end
         end
         S_PAD: begin
            cmd.push = sha512_pkg::PUSH_PAD;
            pad_in   = 1'b0;
            state_in = (status.fill == 4'd15) ? S_START : S_ZERO;
         end
         S_ZERO: begin
            // length goes in the last two slots; a pad in slot 14 forces one more block
            if (status.fill == 4'd14) begin
               cmd.push = sha512_pkg::PUSH_LENH;
               state_in = S_LENL;
            end else begin
               cmd.push = sha512_pkg::PUSH_ZERO;
               state_in = (status.fill == 4'd15) ? S_START : S_ZERO;
            end
         end
         S_LENL: begin
            cmd.push  = sha512_pkg::PUSH_LENL;
            len_in_in = 1'b1;
            state_in  = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (status.last_round) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            // without the length words in yet, another block follows
            if (!final_ff)      state_in = S_IDLE;
            else if (pad_ff)    state_in = S_PAD;
            else if (len_in_ff) state_in = S_OUT;
            else                state_in = S_ZERO;
         end
         S_OUT: if (!rsp_stall) begin
            cmd.shift_out = 1'b1;
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               cmd.reinit = 1'b1;
               final_in   = 1'b0;
               len_in_in  = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         final_ff  <= 1'b0;
         pad_ff    <= 1'b0;
         idx_ff    <= 3'd0;
         len_in_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         final_ff  <= final_in;
         pad_ff    <= pad_in;
         idx_ff    <= idx_in;
         len_in_ff <= len_in_in;
      end
   end

endmodule

// ===== rtl/sha512_hash_engine.sv =====
// SHA-512 hash engine top level: controller plus datapath.
// Depends on sha512_pkg, sha512_ctrl, sha512_dp.
`timescale 1ns / 1ps
// The message arrives as big-endian 64-bit words on the req_ channel; a word
// with req_final_word set is the last and carries req_byte_count valid bytes
// (0..8, counts above 8 read as 8). A non-final word that closes a 16-word
// block is then compressed: a start step, 80 rounds of the single shared
// round unit and one chain update. The final word adds padding, pushed one
// word at a time, and one or two compressions, then the eight digest words
// leave on rsp_, index 0 first, digest_end on the eighth. The round unit
// sets the throughput.
// The engine takes one word at a time; req_stall is high while it works.
module sha512_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_end
);

   sha512_pkg::dp_cmd_type    cmd;
   sha512_pkg::dp_status_type status;
   logic [3:0] bytes;

   // non-final words always count eight bytes
   assign bytes = req_final_word ? req_byte_count : 4'd8;

   sha512_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_byte_count, .req_final_word,
      .rsp_valid, .rsp_stall, .rsp_word_index, .rsp_digest_end, .cmd, .status
   );

   sha512_dp u_dp (
      .clock, .reset, .cmd, .in_word(req_data_word), .in_bytes(bytes),
      .status, .out_word(rsp_digest_word)
   );

endmodule

// ===== rtl/sha512_checker.sv =====
// Port-level checks for sha512_hash_engine, bound to the top level.
// Depends on sha512_hash_engine ports only.
`timescale 1ns / 1ps
module sha512_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_digest_end
);
   a_end_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_end == (rsp_word_index == 3'd7)))
      else $error("digest_end mismatch");
   a_no_in_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during output");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_digest_end) |=> (rsp_valid &&
         rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words not consecutive");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("stalled digest word changed");
endmodule

bind sha512_hash_engine sha512_checker u_chk (.*);
